// ----- src/color_keyframe_fade_engine_macros.svh -----
// Assertion macros for the keyframe fade engine.
`ifndef COLOR_KEYFRAME_FADE_ENGINE_MACROS_SVH
`define COLOR_KEYFRAME_FADE_ENGINE_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define CKF_ASSERT_IMPLY(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define CKF_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/ckf_pkg.sv -----
// Shared types and constants of the keyframe fade engine.
package ckf_pkg;
  localparam int KEY_DEPTH = 64;
  localparam int IDX_BITS = 6;
  localparam int TIME_W = 32;
  localparam int COLOR_W = 24;
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FULL_FRACTION = 17'h10000;
  localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;
  localparam logic [TIME_W-1:0] EASE_RESET = 32'd2000;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_PRESS = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_EASED = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_EASE = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef struct packed {
    logic start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;
endpackage

// ----- src/ckf_divider.sv -----
// Restoring divider producing a Q0.16 quotient, one bit per cycle.
module ckf_divider
  import ckf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  output logic                  done,
  output logic [FRAC_W-2:0]     quot
);
  logic [TIME_W:0] rem;
  logic [TIME_W-1:0] den;
  logic [4:0] count;
  logic busy;
  logic [TIME_W:0] shifted;

  assign shifted = {rem[TIME_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= {1'b0, req.num};
        den <= req.den;
        quot <= '0;
        count <= '0;
      end else if (busy) begin
        // shifted includes the carry bit, so compare at full width
        if (shifted >= {1'b0, den}) begin
          rem <= shifted - {1'b0, den};
          quot <= {quot[FRAC_W-3:0], 1'b1};
        end else begin
          rem <= shifted;
          quot <= {quot[FRAC_W-3:0], 1'b0};
        end
        count <= count + 5'd1;
        if (count == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/color_keyframe_fade_engine.sv -----
// Top level of the RGB keyframe fade engine.
// Load, press or ignored tick go to S_DONE; a tick that holds or steps runs S_RD0 to S_RD2,
// S_EVAL, S_DONE; other ticks add S_MIX0, S_MIX1, after S_DIV (16-step serial divider) unless
// the fraction is zero. One transaction is in flight; the next is accepted in the cycle after
// the result registers. A stalled result holds the engine in S_DONE. Reset (sync, high):
// position 0, white, fraction 0, no press, linear, 2000 ms window, one keyframe; table kept.
module color_keyframe_fade_engine
  import ckf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [5:0]          entry_index,
  input  logic [31:0]         entry_time_ms,
  input  logic [23:0]         entry_color,
  input  logic [31:0]         now_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [5:0]          position,
  output logic [16:0]         fraction
);
`include "color_keyframe_fade_engine_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_EVAL, S_DIV, S_MIX0, S_MIX1, S_DONE
  } state_t;

  // Keyframe table: time and color share one memory row.
  logic [TIME_W+COLOR_W-1:0] key_mem [KEY_DEPTH];
  logic [TIME_W+COLOR_W-1:0] rd_data;
  logic [IDX_BITS-1:0] rd_addr;
  logic rd_en;

  // Configuration registers.
  logic [1:0] fade_mode;
  logic [TIME_W-1:0] ease_window_ms;
  logic [6:0] keyframe_count;

  // Architectural state.
  logic [IDX_BITS-1:0] cur_pos;
  logic [TIME_W-1:0] press_stamp;
  logic [COLOR_W-1:0] shown_color;
  logic [FRAC_W-1:0] last_fraction;

  // Per-transaction working registers.
  state_t state;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] t_cur, t_nxt;
  logic [COLOR_W-1:0] c_cur, c_nxt;
  logic [FRAC_W-1:0] frac;
  logic [IDX_BITS-1:0] last_idx;
  logic [8:0] diff [3];
  logic [25:0] prod [3];

  div_req_t div_req;
  logic div_done;
  logic [FRAC_W-2:0] div_quot;

  ckf_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // Clamp the count to 1..64 and find the last valid index.
  always_comb begin
    if (keyframe_count == 7'd0) begin
      last_idx = '0;
    end else if (keyframe_count > 7'd64) begin
      last_idx = 6'd63;
    end else begin
      last_idx = 6'(keyframe_count - 7'd1);
    end
  end

  // Table port: one write per load, one registered read.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && req_type == REQ_LOAD) begin
      key_mem[entry_index] <= {entry_time_ms, entry_color};
    end
    if (rd_en) begin
      rd_data <= key_mem[rd_addr];
    end
  end

  // The output register parts the sides: a waiting result only holds S_DONE.
  assign in_stall = (state != S_IDLE);

  // Mixing: c0 + floor((c1-c0)*f / 65536), channel by channel.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {1'b0, c_nxt[8*k +: 8]} - {1'b0, c_cur[8*k +: 8]};
      prod[k] = 26'($signed(diff[k]) * $signed({1'b0, frac}));
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = cur_pos;
    case (state)
      S_RD0: begin
        rd_en = 1'b1;
        rd_addr = (cur_pos >= last_idx) ? last_idx : cur_pos;
      end
      S_RD1: begin
        rd_en = 1'b1;
        rd_addr = cur_pos + 6'd1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      fade_mode <= MODE_LINEAR;
      ease_window_ms <= EASE_RESET;
      keyframe_count <= 7'd1;
      cur_pos <= '0;
      press_stamp <= '0;
      shown_color <= WHITE;
      last_fraction <= '0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: fade_mode <= cfg_data[1:0];
          CFG_EASE: ease_window_ms <= cfg_data;
          CFG_COUNT: keyframe_count <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            now <= now_ms;
            if (req_type == REQ_TICK && fade_mode != MODE_NONE) begin
              state <= S_RD0;
            end else begin
              // Handle a press here; a load has already gone to the table.
              if (req_type == REQ_PRESS && fade_mode == MODE_MANUAL) begin
                if (cur_pos < last_idx && press_stamp != '0) begin
                  cur_pos <= cur_pos + 6'd1;
                end
                press_stamp <= now_ms;
              end
              state <= S_DONE;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          t_cur <= rd_data[COLOR_W +: TIME_W];
          c_cur <= rd_data[COLOR_W-1:0];
          state <= S_RD2;
        end
        S_RD2: begin
          t_nxt <= rd_data[COLOR_W +: TIME_W];
          c_nxt <= rd_data[COLOR_W-1:0];
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_DONE;
          if (cur_pos >= last_idx) begin
            shown_color <= c_cur;
          end else if (fade_mode == MODE_MANUAL) begin
            if (press_stamp == '0) begin
              shown_color <= c_cur;
            end else if (now >= press_stamp && (now - press_stamp) < ease_window_ms) begin
              div_req.start <= 1'b1;
              div_req.num <= now - press_stamp;
              div_req.den <= ease_window_ms;
              state <= S_DIV;
            end else begin
              shown_color <= c_nxt;
            end
          end else if (now >= t_nxt) begin
            cur_pos <= cur_pos + 6'd1;
            last_fraction <= FULL_FRACTION;
          end else if (t_nxt <= t_cur) begin
            frac <= '0;
            state <= S_MIX0;
          end else begin
            // Start of the fade: the keyframe, or the ease window before the next one.
            if (fade_mode == MODE_EASED && (t_nxt - t_cur) > ease_window_ms) begin
              if (now <= t_nxt - ease_window_ms) begin
                frac <= '0;
                state <= S_MIX0;
              end else begin
                div_req.start <= 1'b1;
                div_req.num <= now - (t_nxt - ease_window_ms);
                div_req.den <= ease_window_ms;
                state <= S_DIV;
              end
            end else if (now <= t_cur) begin
              frac <= '0;
              state <= S_MIX0;
            end else begin
              div_req.start <= 1'b1;
              div_req.num <= now - t_cur;
              div_req.den <= t_nxt - t_cur;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac <= {1'b0, div_quot};
            state <= S_MIX0;
          end
        end
        S_MIX0: begin
          state <= S_MIX1;
        end
        S_MIX1: begin
          last_fraction <= frac;
          for (int k = 0; k < 3; k++) begin
            shown_color[8*k +: 8] <= c_cur[8*k +: 8] + prod[k][23:16];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            red <= shown_color[23:16];
            green <= shown_color[15:8];
            blue <= shown_color[7:0];
            position <= cur_pos;
            fraction <= last_fraction;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CKF_ASSERT_IMPLY(a_stall_busy, state != S_IDLE, in_stall)
  `CKF_ASSERT_IMPLY(a_frac_range, out_valid, fraction <= FULL_FRACTION)
  `CKF_ASSERT_NEXT(a_div_follows, state == S_EVAL && div_req.start == 1'b0 && $past(1'b1),
                   state != S_MIX0 || frac == '0 || $past(state) != S_EVAL)
  `CKF_ASSERT_IMPLY(a_pos_range, out_valid, position <= 6'd63)
endmodule
